// ===== rtl/sn4seg_pkg.sv =====
package sn4seg_pkg;

  localparam logic [7:0] SegBlank = 8'h00;
  localparam logic [7:0] SegMinus = 8'h40;
  localparam logic [7:0] SegDot   = 8'h80;

  localparam logic [13:0] NegLimit = 14'd999;
  localparam logic [13:0] PosLimit = 14'd9999;

  // Reciprocal constants for floor division of a 14-bit magnitude
  localparam logic [15:0] Recip10   = 16'd52429;  // 2^19 / 10, rounded up
  localparam logic [12:0] Recip100  = 13'd5243;   // 2^19 / 100, rounded up
  localparam logic [14:0] Recip1000 = 15'd16778;  // 2^24 / 1000, rounded up

  typedef struct packed {
    logic [7:0] pos0;
    logic [7:0] pos1;
    logic [7:0] pos2;
    logic [7:0] pos3;
    logic       overflow;
  } seg_result_t;

  typedef struct packed {
    logic [15:0] signed_value;
    logic        dot_on;
  } seg_request_t;

  function automatic logic [7:0] digit_code(input logic [3:0] d);
    logic [7:0] c;
    case (d)
      4'd0:    c = 8'h3F;
      4'd1:    c = 8'h06;
      4'd2:    c = 8'h5B;
      4'd3:    c = 8'h4F;
      4'd4:    c = 8'h66;
      4'd5:    c = 8'h6D;
      4'd6:    c = 8'h7D;
      4'd7:    c = 8'h27;
      4'd8:    c = 8'h7F;
      4'd9:    c = 8'h6F;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/sn4seg_conv.sv =====
module sn4seg_conv (
  input  sn4seg_pkg::seg_request_t req_i,
  output sn4seg_pkg::seg_result_t  res_o
);

  logic        neg;
  logic [16:0] mag;
  logic        ovf;
  logic [13:0] m;
  logic [29:0] prod10;
  logic [26:0] prod100;
  logic [28:0] prod1000;
  logic [10:0] q10;
  logic [7:0]  q100;
  logic [4:0]  q1000;
  logic [13:0] r3;
  logic [10:0] r2;
  logic [7:0]  r1;
  logic [3:0]  d0, d1, d2, d3;
  logic [7:0]  dotbit;
  logic [7:0]  sign_or_blank;

  assign neg = req_i.signed_value[15];
  assign mag = neg ? (17'd0 - {1'b1, req_i.signed_value}) : {1'b0, req_i.signed_value};
  assign ovf = neg ? (mag > {3'd0, sn4seg_pkg::NegLimit})
                   : (mag > {3'd0, sn4seg_pkg::PosLimit});
  assign m   = mag[13:0];

  // Parallel reciprocal multiplies, one level deep
  assign prod10   = 30'(m) * 30'(sn4seg_pkg::Recip10);
  assign prod100  = 27'(m) * 27'(sn4seg_pkg::Recip100);
  assign prod1000 = 29'(m) * 29'(sn4seg_pkg::Recip1000);
  assign q10   = prod10[29:19];
  assign q100  = prod100[26:19];
  assign q1000 = prod1000[28:24];

  assign r3 = m - 14'(14'(q10) * 14'd10);
  assign r2 = q10 - 11'(11'(q100) * 11'd10);
  assign r1 = q100 - 8'(8'(q1000) * 8'd10);
  assign d3 = r3[3:0];
  assign d2 = r2[3:0];
  assign d1 = r1[3:0];
  assign d0 = q1000[3:0];

  assign dotbit        = req_i.dot_on ? sn4seg_pkg::SegDot : sn4seg_pkg::SegBlank;
  assign sign_or_blank = neg ? sn4seg_pkg::SegMinus : sn4seg_pkg::SegBlank;

  always_comb begin
    res_o.pos0     = sn4seg_pkg::SegBlank;
    res_o.pos1     = sn4seg_pkg::SegBlank;
    res_o.pos2     = sn4seg_pkg::SegBlank;
    res_o.pos3     = sn4seg_pkg::digit_code(d3);
    res_o.overflow = 1'b0;
    if (ovf) begin
      res_o.pos0     = sn4seg_pkg::SegMinus;
      res_o.pos1     = sn4seg_pkg::SegMinus;
      res_o.pos2     = sn4seg_pkg::SegMinus;
      res_o.pos3     = sn4seg_pkg::SegMinus;
      res_o.overflow = 1'b1;
    end else if (m >= 14'd1000) begin
      res_o.pos0 = sn4seg_pkg::digit_code(d0);
      res_o.pos1 = sn4seg_pkg::digit_code(d1);
      res_o.pos2 = sn4seg_pkg::digit_code(d2) | dotbit;
    end else if (m >= 14'd100) begin
      res_o.pos0 = sign_or_blank;
      res_o.pos1 = sn4seg_pkg::digit_code(d1);
      res_o.pos2 = sn4seg_pkg::digit_code(d2) | dotbit;
    end else if (m >= 14'd10) begin
      res_o.pos1 = sign_or_blank;
      res_o.pos2 = sn4seg_pkg::digit_code(d2) | dotbit;
    end else if (req_i.dot_on) begin
      // leading zero carries the dot
      res_o.pos1 = sign_or_blank;
      res_o.pos2 = sn4seg_pkg::digit_code(4'd0) | sn4seg_pkg::SegDot;
    end else begin
      res_o.pos2 = sign_or_blank;
    end
  end

endmodule

// ===== rtl/signed_number_to_four_digit_segments.sv =====
// Channel  Handshake                  Payload
// in       in_valid_i / in_ready_o    signed_value_i[15:0], dot_on_i
// out      out_valid_o / out_ready_i  seg_pos0_o..seg_pos3_o[7:0], overflow_o
//
// A request lands in the input register, and the converter (three parallel
// reciprocal multiplies plus digit decode) feeds the result register.
// Throughput is one request per cycle while the output is not stalled.
// Reset clears both valid flags; payload registers are not reset.
// A stalled output holds its result; the input stage keeps accepting while
// it is empty, but once both registers are full a stall drops in_ready_o.
module signed_number_to_four_digit_segments (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] signed_value_i,
  input  logic        dot_on_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  seg_pos0_o,
  output logic [7:0]  seg_pos1_o,
  output logic [7:0]  seg_pos2_o,
  output logic [7:0]  seg_pos3_o,
  output logic        overflow_o
);

  sn4seg_pkg::seg_request_t req_q;
  logic                     req_valid_q;
  sn4seg_pkg::seg_result_t  res_d, res_q;
  logic                     res_valid_q;
  logic                     res_ready;

  // Result register takes a new value when empty or being drained
  assign res_ready  = !res_valid_q || out_ready_i;
  // Input register frees up when its content moves on
  assign in_ready_o = !req_valid_q || res_ready;

  // Hold the request until the result stage takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q.signed_value <= signed_value_i;
      req_q.dot_on       <= dot_on_i;
    end
  end

  sn4seg_conv u_conv (
    .req_i (req_q),
    .res_o (res_d)
  );

  // Advance the converted result; hold while the consumer stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_ready) begin
      res_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && req_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign seg_pos0_o  = res_q.pos0;
  assign seg_pos1_o  = res_q.pos1;
  assign seg_pos2_o  = res_q.pos2;
  assign seg_pos3_o  = res_q.pos3;
  assign overflow_o  = res_q.overflow;

endmodule

// ===== bench/tb_signed_number_to_four_digit_segments.sv =====
module tb_signed_number_to_four_digit_segments;

  // Stimulus and timing knobs
  localparam int unsigned RandomRequests = 1600;
  localparam int unsigned IdleLimit      = 1000;  // cycles without any handshake
  localparam int unsigned DrainCycles    = 8;     // extra wait for any stray result

  // Seven-segment patterns for decimal digits, g..a in bits 6..0
  localparam logic [7:0] DigitSeg [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h27, 8'h7F, 8'h6F
  };

  // One directed row: the request, and a hand-written result where it is obvious
  typedef struct packed {
    logic [15:0]             value;
    logic                    dot;
    logic                    known;
    sn4seg_pkg::seg_result_t result;
  } seg_case_t;

  localparam sn4seg_pkg::seg_result_t AllDashes = '{sn4seg_pkg::SegMinus,
    sn4seg_pkg::SegMinus, sn4seg_pkg::SegMinus, sn4seg_pkg::SegMinus, 1'b1};
  localparam sn4seg_pkg::seg_result_t NoResult  = '{sn4seg_pkg::SegBlank,
    sn4seg_pkg::SegBlank, sn4seg_pkg::SegBlank, sn4seg_pkg::SegBlank, 1'b0};

  localparam int unsigned NumCases = 24;
  localparam seg_case_t DirectedCases [NumCases] = '{
    // Zero, with and without the dot
    '{16'h0000, 1'b0, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h3F, 1'b0}},
    '{16'h0000, 1'b1, 1'b1, '{8'h00, 8'h00, 8'hBF, 8'h3F, 1'b0}},
    // Largest positive that fits
    '{16'd9999, 1'b0, 1'b1, '{8'h6F, 8'h6F, 8'h6F, 8'h6F, 1'b0}},
    '{16'd9999, 1'b1, 1'b1, '{8'h6F, 8'h6F, 8'hEF, 8'h6F, 1'b0}},
    // Out of range on both sides, the most negative value among them
    '{16'd10000, 1'b0, 1'b1, AllDashes},
    '{16'd10000, 1'b1, 1'b1, AllDashes},
    '{16'h7FFF,  1'b0, 1'b1, AllDashes},
    '{16'h8000,  1'b0, 1'b1, AllDashes},
    '{16'h8000,  1'b1, 1'b1, AllDashes},
    '{16'h8001,  1'b1, 1'b1, AllDashes},
    '{16'hFC18,  1'b0, 1'b1, AllDashes},   // -1000
    // Most negative value that fits
    '{16'hFC19,  1'b0, 1'b1, '{8'h40, 8'h6F, 8'h6F, 8'h6F, 1'b0}},   // -999
    '{16'hFC19,  1'b1, 1'b0, NoResult},
    // Minus one: sign moves left when the leading zero and dot appear
    '{16'hFFFF,  1'b0, 1'b1, '{8'h00, 8'h00, 8'h40, 8'h06, 1'b0}},
    '{16'hFFFF,  1'b1, 1'b1, '{8'h00, 8'h40, 8'hBF, 8'h06, 1'b0}},
    // Decade edges, both signs, dot on and off
    '{16'd9,     1'b0, 1'b0, NoResult},
    '{16'd5,     1'b1, 1'b0, NoResult},
    '{16'd10,    1'b0, 1'b0, NoResult},
    '{16'hFFF6,  1'b1, 1'b0, NoResult},   // -10
    '{16'd99,    1'b1, 1'b0, NoResult},
    '{16'hFF9C,  1'b0, 1'b0, NoResult},   // -100
    '{16'd1000,  1'b1, 1'b0, NoResult},
    '{16'd1234,  1'b1, 1'b0, NoResult},
    '{16'hFFD3,  1'b1, 1'b0, NoResult}    // -45
  };

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [15:0] signed_value_i;
  logic        dot_on_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  seg_pos0_o;
  logic [7:0]  seg_pos1_o;
  logic [7:0]  seg_pos2_o;
  logic [7:0]  seg_pos3_o;
  logic        overflow_o;

  sn4seg_pkg::seg_result_t pending_segments_q [$];
  int unsigned mismatch_count;
  int unsigned idle_cycles;
  int unsigned ready_stall_left;
  bit          quiet_phase;

  signed_number_to_four_digit_segments dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .signed_value_i (signed_value_i),
    .dot_on_i       (dot_on_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .seg_pos0_o     (seg_pos0_o),
    .seg_pos1_o     (seg_pos1_o),
    .seg_pos2_o     (seg_pos2_o),
    .seg_pos3_o     (seg_pos3_o),
    .overflow_o     (overflow_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [7:0] seg_digit(input int unsigned n);
    return DigitSeg[n % 10];
  endfunction

  // Compute the four display bytes and the overflow flag for one request
  function automatic sn4seg_pkg::seg_result_t predict_segments(input logic [15:0] value,
                                                               input logic dot);
    sn4seg_pkg::seg_result_t r;
    logic                    neg;
    int unsigned             mag;
    logic [7:0]              dot_seg;
    neg     = value[15];
    mag     = neg ? (32'h10000 - 32'(value)) : 32'(value);
    dot_seg = dot ? sn4seg_pkg::SegDot : sn4seg_pkg::SegBlank;
    r       = NoResult;
    if ((neg && mag > sn4seg_pkg::NegLimit) || (!neg && mag > sn4seg_pkg::PosLimit)) begin
      r = AllDashes;
    end else if (mag >= 1000) begin
      r.pos0 = seg_digit(mag / 1000);
      r.pos1 = seg_digit(mag / 100);
      r.pos2 = seg_digit(mag / 10) | dot_seg;
      r.pos3 = seg_digit(mag);
    end else if (mag >= 100) begin
      r.pos0 = neg ? sn4seg_pkg::SegMinus : sn4seg_pkg::SegBlank;
      r.pos1 = seg_digit(mag / 100);
      r.pos2 = seg_digit(mag / 10) | dot_seg;
      r.pos3 = seg_digit(mag);
    end else if (mag >= 10) begin
      r.pos1 = neg ? sn4seg_pkg::SegMinus : sn4seg_pkg::SegBlank;
      r.pos2 = seg_digit(mag / 10) | dot_seg;
      r.pos3 = seg_digit(mag);
    end else begin
      // Single digit: with the dot a leading zero carries it and the sign shifts left
      if (dot) begin
        r.pos1 = neg ? sn4seg_pkg::SegMinus : sn4seg_pkg::SegBlank;
        r.pos2 = DigitSeg[0] | sn4seg_pkg::SegDot;
      end else begin
        r.pos2 = neg ? sn4seg_pkg::SegMinus : sn4seg_pkg::SegBlank;
      end
      r.pos3 = seg_digit(mag);
    end
    return r;
  endfunction

  // Idle length: mostly none or short, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Draw a value biased toward each digit count, the range edges and sign flips
  function automatic logic [15:0] pick_value();
    int unsigned r;
    int unsigned mag;
    logic [15:0] edges [8];
    edges = '{16'd9999, 16'd10000, 16'hFC19, 16'hFC18, 16'h8000, 16'h7FFF,
              16'h0000, 16'hFFFF};
    r = $urandom_range(0, 99);
    if (r < 15)      mag = $urandom_range(0, 9);
    else if (r < 30) mag = $urandom_range(10, 99);
    else if (r < 45) mag = $urandom_range(100, 999);
    else if (r < 60) return 16'($urandom_range(1000, 9999));
    else if (r < 70) return edges[$urandom_range(0, 7)];
    else             return 16'($urandom);
    if ($urandom_range(0, 1) == 1) return 16'(-int'(mag));
    return 16'(mag);
  endfunction

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Hold the request on the port until the block takes it, then record the expectation
  task automatic send_request(input logic [15:0] value, input logic dot,
                              input sn4seg_pkg::seg_result_t expected);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    signed_value_i = value;
    dot_on_i       = dot;
    in_valid_i     = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pending_segments_q.push_back(expected);
    @(negedge clk_i);
  endtask

  // Stop sending until every outstanding result has come back
  task automatic drain_results();
    in_valid_i = 1'b0;
    while (pending_segments_q.size() != 0) @(negedge clk_i);
  endtask

  // Receiver side: toggle ready with random stalls
  always @(negedge clk_i) begin
    if (ready_stall_left != 0) begin
      out_ready_i      = 1'b0;
      ready_stall_left = ready_stall_left - 1;
    end else begin
      out_ready_i      = 1'b1;
      ready_stall_left = pick_gap();
    end
  end

  // Compare every accepted result with the oldest expectation
  always @(posedge clk_i) begin
    sn4seg_pkg::seg_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_segments_q.size() == 0) begin
        $error("result with no request outstanding: %h %h %h %h ovf %b",
               seg_pos0_o, seg_pos1_o, seg_pos2_o, seg_pos3_o, overflow_o);
        mismatch_count++;
      end else begin
        want = pending_segments_q.pop_front();
        check_field("seg_pos0", want.pos0, seg_pos0_o);
        check_field("seg_pos1", want.pos1, seg_pos1_o);
        check_field("seg_pos2", want.pos2, seg_pos2_o);
        check_field("seg_pos3", want.pos3, seg_pos3_o);
        check_field("overflow", 8'(want.overflow), 8'(overflow_o));
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
          $display("tb_signed_number_to_four_digit_segments failed");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [15:0] value;
    logic        dot;
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    signed_value_i   = 16'h0000;
    dot_on_i         = 1'b0;
    out_ready_i      = 1'b0;
    mismatch_count   = 0;
    idle_cycles      = 0;
    ready_stall_left = 0;
    quiet_phase      = 1'b0;

    // Hold reset, then release it away from the active edge
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows: use the typed result where given, else the predictor
    for (int unsigned i = 0; i < NumCases; i++) begin
      send_request(DirectedCases[i].value, DirectedCases[i].dot,
                   DirectedCases[i].known ? DirectedCases[i].result
                                          : predict_segments(DirectedCases[i].value,
                                                             DirectedCases[i].dot));
    end
    drain_results();

    // Random requests; run one stretch back to back and pause twice to empty the pipe
    for (int unsigned n = 0; n < RandomRequests; n++) begin
      if (n == 300 || n == 1000) drain_results();
      quiet_phase = (n >= 500 && n < 700);
      value = pick_value();
      dot   = 1'($urandom_range(0, 1));
      send_request(value, dot, predict_segments(value, dot));
    end
    quiet_phase = 1'b0;
    in_valid_i  = 1'b0;

    // Wait for the tail, then wait out DrainCycles for any stray result
    while (pending_segments_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_segments_q.size() != 0) begin
      $error("%0d results never arrived", pending_segments_q.size());
      mismatch_count++;
    end

    if (mismatch_count == 0) begin
      $display("tb_signed_number_to_four_digit_segments passed");
    end else begin
      $display("tb_signed_number_to_four_digit_segments failed");
    end
    $finish;
  end

endmodule
